// ===== rtl/tvd_pkg.sv =====
// ----------------------------------------------------------------------------
// tvd_pkg
// shared types, codes and helpers for the 1-d tv denoising block
// ----------------------------------------------------------------------------
`default_nettype none

package tvd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = 6;
    localparam int LAMBDA_W = 16;
    localparam int SLOPE_W  = 8;
    localparam int ACC_W    = 24;
    localparam int WIDE_W   = 64;
    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 16'd256;

    // clip modes
    localparam logic [1:0] MODE_LO  = 2'd0;
    localparam logic [1:0] MODE_HI  = 2'd1;
    localparam logic [1:0] MODE_FIN = 2'd2;

    typedef struct packed {
        logic       ld_in;
        logic       init_l;
        logic       init_r;
        logic       clip_start;
        logic [1:0] mode;
        logic       mul_a;
        logic       mul_s;
        logic       step;
        logic       fin_ptr;
        logic       div_start;
        logic       wr_knot;
        logic       commit;
        logic       ld_v;
        logic       push;
        logic       push_single;
        logic       clamp;
    } t_cmd;

    typedef struct packed {
        logic       cnt_zero;
        logic       is_last;
        logic       loop_ok;
        logic       cond;
        logic       div_done;
        logic       k_zero;
        logic       out_free;
        logic [1:0] mode;
    } t_sts;

    // saturate a wide value to the signed q16.16 range
    function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        if (v > $signed(64'sh0000_0000_7fff_ffff)) begin
            sat32 = 32'sh7fff_ffff;
        end else if (v < $signed(64'shffff_ffff_8000_0000)) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[VALUE_W-1:0];
        end
    endfunction

    // saturate an accumulated slope to 8 bits
    function automatic logic signed [SLOPE_W-1:0] sat8(input logic signed [ACC_W-1:0] v);
        if (v > $signed(24'sd127)) begin
            sat8 = 8'sd127;
        end else if (v < $signed(-24'sd128)) begin
            sat8 = -8'sd128;
        end else begin
            sat8 = v[SLOPE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tvd_ifs.sv =====
// ----------------------------------------------------------------------------
// tvd_in_if / tvd_out_if
// valid/ready channels for samples and denoised results
// ----------------------------------------------------------------------------
`default_nettype none

interface tvd_in_if;
    import tvd_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface tvd_out_if;
    import tvd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          index;
    logic                      end_of_run;
    modport source (output valid, output value, output index, output end_of_run, input ready);
    modport sink   (input valid, input value, input index, input end_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/tvd_ram.sv =====
// ----------------------------------------------------------------------------
// tvd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tvd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/tvd_div.sv =====
// ----------------------------------------------------------------------------
// tvd_div
// radix-2 restoring divider, truncating, result saturated to q16.16
// ----------------------------------------------------------------------------
`default_nettype none

module tvd_div
    import tvd_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic signed [WIDE_W-1:0]  i_num,
    input  wire logic signed [ACC_W-1:0]   i_den,
    output logic                           o_done,
    output logic signed [VALUE_W-1:0]      o_q
);

    localparam int CNT_W = $clog2(WIDE_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WIDE_W-1:0] r_dvd;
    logic [ACC_W-1:0]  r_dsr;
    logic [ACC_W-1:0]  r_rem;
    logic              r_neg;
    logic signed [VALUE_W-1:0] r_q;

    logic [ACC_W:0]    w_trial;
    logic [ACC_W:0]    w_diff;
    logic [WIDE_W-1:0] w_num_mag;
    logic [ACC_W-1:0]  w_den_mag;

    assign w_num_mag = i_num[WIDE_W-1] ? WIDE_W'(-i_num) : WIDE_W'(i_num);
    assign w_den_mag = i_den[ACC_W-1] ? ACC_W'(-i_den) : ACC_W'(i_den);
    assign w_trial   = {r_rem, r_dvd[WIDE_W-1]};
    assign w_diff    = w_trial - {1'b0, r_dsr};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(WIDE_W);
                end
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // shift/subtract datapath and signed saturation of the quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= w_num_mag;
            r_dsr <= w_den_mag;
            r_rem <= '0;
            r_neg <= i_num[WIDE_W-1] ^ i_den[ACC_W-1];
            if (i_den == '0) begin
                if (i_num > 0) begin
                    r_q <= 32'sh7fff_ffff;
                end else if (i_num < 0) begin
                    r_q <= 32'sh8000_0000;
                end else begin
                    r_q <= '0;
                end
            end
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                if (r_neg) begin
                    if (r_dvd > 64'h0000_0000_8000_0000) begin
                        r_q <= 32'sh8000_0000;
                    end else begin
                        r_q <= VALUE_W'(-r_dvd);
                    end
                end else if (r_dvd > 64'h0000_0000_7fff_ffff) begin
                    r_q <= 32'sh7fff_ffff;
                end else begin
                    r_q <= r_dvd[VALUE_W-1:0];
                end
            end else if (!w_diff[ACC_W]) begin
                r_rem <= w_diff[ACC_W-1:0];
                r_dvd <= {r_dvd[WIDE_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[ACC_W-1:0];
                r_dvd <= {r_dvd[WIDE_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

`default_nettype wire

// ===== rtl/tvd_dp.sv =====
// ----------------------------------------------------------------------------
// tvd_dp
// datapath: knot deque, bound stores, clip arithmetic, divider, output beat
// ----------------------------------------------------------------------------
`default_nettype none

module tvd_dp
    import tvd_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cmd                       i_cmd,
    output t_sts                            o_sts,
    input  wire logic                       i_lambda_we,
    input  wire logic [LAMBDA_W-1:0]        i_lambda,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic                       i_last,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic signed [VALUE_W-1:0]       o_value,
    output logic [IDX_W-1:0]                o_index,
    output logic                            o_end_of_run
);

    localparam int KD  = 2 * MAX_LEN;
    localparam int KAW = $clog2(KD);
    localparam int BAW = $clog2(MAX_LEN);
    localparam int PW  = KAW + 2;
    localparam int KW  = SLOPE_W + VALUE_W;

    // clamp a queue pointer into the store range
    function automatic logic [KAW-1:0] kx(input logic signed [PW-1:0] p);
        if (p < 0) begin
            kx = '0;
        end else if (p > $signed(PW'(KD - 1))) begin
            kx = KAW'(KD - 1);
        end else begin
            kx = p[KAW-1:0];
        end
    endfunction

    logic [LAMBDA_W-1:0]        r_lam;
    logic signed [SAMPLE_W-1:0] r_y;
    logic                       r_is_last;
    logic [BAW-1:0]             r_cnt;
    logic [BAW-1:0]             r_k;
    logic signed [PW-1:0]       r_l;
    logic signed [PW-1:0]       r_r;
    logic [1:0]                 r_mode;
    logic signed [ACC_W-1:0]    r_a;
    logic signed [WIDE_W-1:0]   r_b;
    logic signed [VALUE_W-1:0]  r_kp;
    logic signed [SLOPE_W-1:0]  r_ks;
    logic signed [WIDE_W-1:0]   r_pa;
    logic signed [WIDE_W-1:0]   r_ps;
    logic signed [VALUE_W-1:0]  r_v;
    logic                       r_ov;
    logic signed [VALUE_W-1:0]  r_oval;
    logic [IDX_W-1:0]           r_oidx;
    logic                       r_oeor;

    logic signed [WIDE_W-1:0]   w_yq;
    logic signed [WIDE_W-1:0]   w_lq;
    logic signed [WIDE_W-1:0]   w_thr;
    logic signed [WIDE_W-1:0]   w_num;
    logic signed [ACC_W+VALUE_W-1:0]   w_pa;
    logic signed [SLOPE_W+VALUE_W-1:0] w_ps;
    logic signed [VALUE_W-1:0]  w_kpos;
    logic signed [SLOPE_W-1:0]  w_kslope;
    logic signed [VALUE_W-1:0]  w_q;
    logic signed [VALUE_W-1:0]  w_lo_init;
    logic signed [VALUE_W-1:0]  w_hi_init;
    logic                       w_div_done;
    logic [KW-1:0]              w_krd;
    logic [KW-1:0]              w_kwd;
    logic [KAW-1:0]             w_kwa;
    logic [KAW-1:0]             w_kra;
    logic                       w_kwe;
    logic [BAW-1:0]             w_bwa;
    logic [BAW-1:0]             w_bra;
    logic                       w_lbwe;
    logic                       w_ubwe;
    logic [VALUE_W-1:0]         w_lbwd;
    logic [VALUE_W-1:0]         w_ubwd;
    logic [VALUE_W-1:0]         w_lbrd;
    logic [VALUE_W-1:0]         w_ubrd;
    logic signed [VALUE_W-1:0]  w_clip_hi;
    logic                       w_out_free;

    // fixed point views of the sample and the penalty
    assign w_yq = {{(WIDE_W-SAMPLE_W-16){r_y[SAMPLE_W-1]}}, r_y, 16'h0000};
    assign w_lq = {{(WIDE_W-LAMBDA_W-16){1'b0}}, r_lam, 16'h0000};
    assign w_lo_init = sat32(w_yq - w_lq);
    assign w_hi_init = sat32(w_yq + w_lq);
    assign w_thr = (r_mode == MODE_FIN) ? '0 : -w_lq;
    assign w_num = (r_mode == MODE_FIN) ? -r_b : (-w_lq - r_b);

    // knot store: {slope, position}
    assign w_kpos   = w_krd[VALUE_W-1:0];
    assign w_kslope = w_krd[KW-1:VALUE_W];
    assign w_kra    = kx((r_mode == MODE_HI) ? r_r : r_l);
    assign w_kwe    = i_cmd.init_l | i_cmd.init_r | i_cmd.wr_knot;
    always_comb begin
        if (i_cmd.init_l) begin
            w_kwa = KAW'(MAX_LEN - 1);
            w_kwd = {8'sd1, w_lo_init};
        end else if (i_cmd.init_r) begin
            w_kwa = KAW'(MAX_LEN);
            w_kwd = {-8'sd1, w_hi_init};
        end else begin
            w_kwa = w_kra;
            w_kwd = {sat8(r_a), w_q};
        end
    end

    tvd_ram #(.WIDTH(KW), .DEPTH(KD)) u_knots (
        .i_clk   (i_clk),
        .i_we    (w_kwe),
        .i_waddr (w_kwa),
        .i_wdata (w_kwd),
        .i_raddr (w_kra),
        .o_rdata (w_krd)
    );

    // bound stores, read back during the backward pass
    assign w_bwa  = (i_cmd.init_l | i_cmd.init_r) ? '0 : r_cnt;
    assign w_bra  = r_k - 1'b1;
    assign w_lbwe = i_cmd.init_l | (i_cmd.wr_knot & (r_mode == MODE_LO));
    assign w_ubwe = i_cmd.init_r | (i_cmd.wr_knot & (r_mode == MODE_HI));
    assign w_lbwd = i_cmd.init_l ? w_lo_init : w_q;
    assign w_ubwd = i_cmd.init_r ? w_hi_init : w_q;

    tvd_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LEN)) u_lower (
        .i_clk   (i_clk),
        .i_we    (w_lbwe),
        .i_waddr (w_bwa),
        .i_wdata (w_lbwd),
        .i_raddr (w_bra),
        .o_rdata (w_lbrd)
    );

    tvd_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LEN)) u_upper (
        .i_clk   (i_clk),
        .i_we    (w_ubwe),
        .i_waddr (w_bwa),
        .i_wdata (w_ubwd),
        .i_raddr (w_bra),
        .o_rdata (w_ubrd)
    );

    tvd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_a),
        .o_done  (w_div_done),
        .o_q     (w_q)
    );

    // products, one multiplier per cycle
    assign w_pa = r_a * w_kpos;
    assign w_ps = r_ks * r_kp;
    assign w_clip_hi = (r_v > $signed(w_ubrd)) ? $signed(w_ubrd) : r_v;

    // penalty register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lam <= LAMBDA_RESET;
        end else if (i_lambda_we) begin
            r_lam <= i_lambda;
        end
    end

    // run control: count and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_l   <= '0;
            r_r   <= '0;
        end else begin
            if (i_cmd.init_l) begin
                r_l <= PW'(MAX_LEN - 1);
            end
            if (i_cmd.init_r) begin
                r_r   <= PW'(MAX_LEN);
                r_cnt <= BAW'(1);
            end
            if (i_cmd.step) begin
                if (r_mode == MODE_HI) begin
                    r_r <= r_r - 1'b1;
                end else begin
                    r_l <= r_l + 1'b1;
                end
            end
            if (i_cmd.fin_ptr) begin
                if (r_mode == MODE_HI) begin
                    r_r <= r_r + 1'b1;
                end else begin
                    r_l <= r_l - 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_l   <= PW'(kx(r_l));
                r_r   <= PW'(kx(r_r));
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.ld_v) begin
                r_cnt <= '0;
                r_l   <= '0;
                r_r   <= '0;
            end
        end
    end

    // clip arithmetic and backward value
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_y       <= i_sample;
            r_is_last <= i_last | (r_cnt == BAW'(MAX_LEN - 1));
        end
        if (i_cmd.clip_start) begin
            r_mode <= i_cmd.mode;
            if (i_cmd.mode == MODE_HI) begin
                r_a <= -24'sd1;
                r_b <= w_yq - w_lq;
            end else begin
                r_a <= 24'sd1;
                r_b <= -w_yq - w_lq;
            end
        end
        if (i_cmd.mul_a) begin
            r_kp <= w_kpos;
            r_ks <= w_kslope;
            r_pa <= WIDE_W'(w_pa);
        end
        if (i_cmd.mul_s) begin
            r_ps <= WIDE_W'(w_ps);
        end
        if (i_cmd.step) begin
            r_b <= r_b - r_ps;
            r_a <= r_a + ACC_W'(r_ks);
        end
        if (i_cmd.ld_v) begin
            r_v <= w_q;
            r_k <= r_cnt;
        end
        if (i_cmd.push && (r_k != '0)) begin
            r_k <= r_k - 1'b1;
        end
        if (i_cmd.clamp) begin
            r_v <= (w_clip_hi < $signed(w_lbrd)) ? $signed(w_lbrd) : w_clip_hi;
        end
    end

    // output beat register
    assign w_out_free = !r_ov || i_out_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.push || i_cmd.push_single) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_oval <= r_v;
            r_oidx <= IDX_W'(r_k);
            r_oeor <= (r_k == '0);
        end else if (i_cmd.push_single) begin
            r_oval <= {r_y, 16'h0000};
            r_oidx <= '0;
            r_oeor <= 1'b1;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_value      = r_oval;
    assign o_index      = r_oidx;
    assign o_end_of_run = r_oeor;

    // status to the controller
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.is_last  = r_is_last;
    assign o_sts.loop_ok  = (r_l <= r_r);
    assign o_sts.cond     = ((r_pa + r_b) <= w_thr);
    assign o_sts.div_done = w_div_done;
    assign o_sts.k_zero   = (r_k == '0);
    assign o_sts.out_free = w_out_free;
    assign o_sts.mode     = r_mode;

endmodule

`default_nettype wire

// ===== rtl/tvd_ctrl.sv =====
// ----------------------------------------------------------------------------
// tvd_ctrl
// sequencer for seeding, clipping loops, divisions and the backward pass
// ----------------------------------------------------------------------------
`default_nettype none

module tvd_ctrl
    import tvd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_SGL   = 4'd2;
    localparam logic [3:0] S_INIT1 = 4'd3;
    localparam logic [3:0] S_INIT2 = 4'd4;
    localparam logic [3:0] S_LRD   = 4'd5;
    localparam logic [3:0] S_LMUL  = 4'd6;
    localparam logic [3:0] S_LCMP  = 4'd7;
    localparam logic [3:0] S_LSTEP = 4'd8;
    localparam logic [3:0] S_LUPD  = 4'd9;
    localparam logic [3:0] S_LEND  = 4'd10;
    localparam logic [3:0] S_LDIV  = 4'd11;
    localparam logic [3:0] S_PUSH  = 4'd12;
    localparam logic [3:0] S_BRD   = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.ld_in = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.cnt_zero && i_sts.is_last) begin
                    n_state = S_SGL;
                end else if (i_sts.cnt_zero) begin
                    n_state = S_INIT1;
                end else begin
                    o_cmd.clip_start = 1'b1;
                    o_cmd.mode       = i_sts.is_last ? MODE_FIN : MODE_LO;
                    n_state          = S_LRD;
                end
            end
            S_SGL: begin
                if (i_sts.out_free) begin
                    o_cmd.push_single = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_INIT1: begin
                o_cmd.init_l = 1'b1;
                n_state      = S_INIT2;
            end
            S_INIT2: begin
                o_cmd.init_r = 1'b1;
                n_state      = S_IDLE;
            end
            S_LRD: begin
                n_state = i_sts.loop_ok ? S_LMUL : S_LEND;
            end
            S_LMUL: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_LCMP;
            end
            S_LCMP: begin
                n_state = i_sts.cond ? S_LSTEP : S_LEND;
            end
            S_LSTEP: begin
                o_cmd.mul_s = 1'b1;
                n_state     = S_LUPD;
            end
            S_LUPD: begin
                o_cmd.step = 1'b1;
                n_state    = S_LRD;
            end
            S_LEND: begin
                o_cmd.fin_ptr   = (i_sts.mode != MODE_FIN);
                o_cmd.div_start = 1'b1;
                n_state         = S_LDIV;
            end
            S_LDIV: begin
                if (i_sts.div_done) begin
                    case (i_sts.mode)
                        MODE_LO: begin
                            o_cmd.wr_knot    = 1'b1;
                            o_cmd.clip_start = 1'b1;
                            o_cmd.mode       = MODE_HI;
                            n_state          = S_LRD;
                        end
                        MODE_HI: begin
                            o_cmd.wr_knot = 1'b1;
                            o_cmd.commit  = 1'b1;
                            n_state       = S_IDLE;
                        end
                        default: begin
                            o_cmd.ld_v = 1'b1;
                            n_state    = S_PUSH;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = i_sts.k_zero ? S_IDLE : S_BRD;
                end
            end
            S_BRD: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_PUSH;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a result beat is loaded only into a free output register
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.push || o_cmd.push_single) |-> i_sts.out_free)
        else $error("result beat loaded over a pending beat");

    // divider finishes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_LDIV))
        else $error("divider result arrived outside the wait state");

    // a division is always followed by the wait for it
    a_div_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> (r_state == S_LDIV))
        else $error("division started without waiting");

    // clamp reads bounds right after a push
    a_clamp_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clamp |-> $past(o_cmd.push))
        else $error("bound clamp without preceding beat");

endmodule

`default_nettype wire

// ===== rtl/tv_denoise_line_dp_top.sv =====
// ----------------------------------------------------------------------------
// tv_denoise_line_dp_top
// 1-d total-variation denoiser, dynamic program over derivative knots
// ----------------------------------------------------------------------------
// One sample is taken per beat; results come out in reverse order after the
// last sample of a run. The first sample of a run seeds the knot deque with
// two knots. A middle sample runs the lower and then the upper clip loop over
// the knots it visits, each loop ending in a 64-step division; the last
// sample runs one clip loop and one division, and then every result beat
// after the first takes one bound store read and clamp. A run of one sample
// returns the sample itself as its only result. The lower, upper and final
// clip loops share the radix-2 divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tv_denoise_line_dp_top
    import tvd_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_lambda_we,
    input  wire logic [LAMBDA_W-1:0] i_lambda,
    tvd_in_if.sink                   i_in_ch,
    tvd_out_if.source                o_out_ch
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    tvd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (i_in_ch.ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // datapath
    tvd_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_lambda_we  (i_lambda_we),
        .i_lambda     (i_lambda),
        .i_sample     (i_in_ch.sample),
        .i_last       (i_in_ch.last),
        .i_out_ready  (o_out_ch.ready),
        .o_out_valid  (o_out_ch.valid),
        .o_value      (o_out_ch.value),
        .o_index      (o_out_ch.index),
        .o_end_of_run (o_out_ch.end_of_run)
    );

endmodule

`default_nettype wire
